@@ rtl/rgbhsv_pkg.sv @@
// rgb to hsv converter package: component width, pixel and result types,
// and the hand-off struct between the front end and the divider pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

  localparam int unsigned CompBits = 16;
  // hue numerator and 6*d need three extra bits
  localparam int unsigned HueW     = CompBits + 3;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CompBits-1:0] hue;
    logic [CompBits-1:0] saturation;
    logic [CompBits-1:0] value;
  } hsv_t;

  // multiple of d that opens the hue sector
  typedef enum logic [1:0] {
    BASE_ONE,
    BASE_THREE,
    BASE_FIVE
  } base_e;

  typedef struct packed {
    logic                valid;
    logic [CompBits-1:0] v;
    logic [CompBits-1:0] d;
    logic [HueW-1:0]     n;
    logic [HueW-1:0]     den6;
    logic                zero;
    logic                sat_full;
  } prep_t;

endpackage

`default_nettype wire

@@ rtl/rgb_to_hsv_converter.sv @@
// rgb to hsv converter top: front end, two divider pipelines, output register
// depends on rgbhsv_pkg, rgbhsv_prep, rgbhsv_divider
//
//   port       dir  type   meaning
//   start      in   1      pixel transfer request
//   busy       out  1      always low, a pixel is taken every cycle
//   pixel_i    in   rgb_t  red, green, blue components
//   done_o     out  1      result strobe, one cycle per pixel
//   result_o   out  hsv_t  hue, saturation, value
//
// one pixel per clock through two front-end stages, one restoring divider stage
// per quotient bit and one output register; the divider chain length sets the
// latency, throughput stays one per cycle
// reset clears the valid bits and the side line only; pixels in flight are dropped
// the receiver cannot stall, so nothing ever holds the pipeline
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire rgb_t pixel_i,
  output logic      done_o,
  output hsv_t      result_o
);

  localparam int unsigned Latency = CompBits + 3;

  typedef struct packed {
    logic                valid;
    logic [CompBits-1:0] v;
    logic                zero;
    logic                sat_full;
    logic                wrap;
  } side_t;

  prep_t               prep;
  logic [CompBits-1:0] sat_quo, hue_quo;
  side_t               side_d;
  side_t               side_q [CompBits];
  logic                done_q;
  hsv_t                result_q, result_d;

  assign busy = 1'b0;

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .pixel_i (pixel_i),
    .prep_o  (prep)
  );

  rgbhsv_divider #(
    .DenW (CompBits),
    .QuoW (CompBits)
  ) u_sat_div (
    .clk_i (clk_i),
    .num_i (prep.d),
    .den_i (prep.v),
    .quo_o (sat_quo)
  );

  rgbhsv_divider #(
    .DenW (HueW),
    .QuoW (CompBits)
  ) u_hue_div (
    .clk_i (clk_i),
    .num_i (prep.n),
    .den_i (prep.den6),
    .quo_o (hue_quo)
  );

  always_comb begin
    side_d.valid    = prep.valid;
    side_d.v        = prep.v;
    side_d.zero     = prep.zero;
    side_d.sat_full = prep.sat_full;
    // a full turn of hue wraps to 0
    side_d.wrap     = (prep.n >= prep.den6);
  end

  // side line runs alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CompBits; k++) side_q[k] <= '0;
    end else begin
      side_q[0] <= side_d;
      for (int k = 1; k < CompBits; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_comb begin
    side_t s;
    s = side_q[CompBits-1];
    result_d.value = s.v;
    if (s.zero) begin
      result_d.hue        = '0;
      result_d.saturation = '0;
    end else begin
      result_d.hue        = s.wrap ? '0 : hue_quo;
      result_d.saturation = s.sat_full ? '1 : sat_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_q[CompBits-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // every accepted pixel comes out after the fixed latency
  a_latency_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted pixel did not produce a result");

  // no result without a pixel accepted the same latency earlier
  a_latency_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !done_o)
    else $error("result strobe without an accepted pixel");

  // zero saturation only for grey, which has zero hue
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.saturation == '0) |-> (result_o.hue == '0))
    else $error("grey pixel with nonzero hue");

  // black has neither hue nor saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.value == '0) |-> (result_o.saturation == '0))
    else $error("black pixel with nonzero saturation");

endmodule

`default_nettype wire

@@ rtl/rgbhsv_prep.sv @@
// rgb to hsv front end: max/min and sector pick, then hue numerator and 6*d
// two register stages; depends on rgbhsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_prep
  import rgbhsv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire rgb_t  pixel_i,
  output prep_t      prep_o
);

  typedef struct packed {
    logic [CompBits-1:0] v;
    logic [CompBits-1:0] d;
    logic                x_zero;
    base_e               base;
    logic                sub;
    logic [CompBits-1:0] diff;
  } sect_t;

  logic  s1_valid_q, s1_valid_d;
  sect_t s1_q, s1_d;
  logic  s2_valid_q;
  prep_t s2_q, s2_d;

  // stage 1: largest, smallest, sector
  always_comb begin
    logic [CompBits-1:0] mx, mn;
    mx = pixel_i.red;
    if (pixel_i.green > mx) mx = pixel_i.green;
    if (pixel_i.blue > mx) mx = pixel_i.blue;
    mn = pixel_i.red;
    if (pixel_i.green < mn) mn = pixel_i.green;
    if (pixel_i.blue < mn) mn = pixel_i.blue;

    s1_valid_d = valid_i;
    s1_d.v      = mx;
    s1_d.d      = mx - mn;
    s1_d.x_zero = (mn == '0);
    // blue max wins over green max, green over red
    if (pixel_i.blue == mx) begin
      if (pixel_i.red == mn) begin
        s1_d.base = BASE_THREE;
        s1_d.sub  = 1'b0;
        s1_d.diff = mx - pixel_i.green;
      end else begin
        s1_d.base = BASE_FIVE;
        s1_d.sub  = 1'b1;
        s1_d.diff = mx - pixel_i.red;
      end
    end else if (pixel_i.green == mx) begin
      if (pixel_i.blue == mn) begin
        s1_d.base = BASE_ONE;
        s1_d.sub  = 1'b0;
        s1_d.diff = mx - pixel_i.red;
      end else begin
        s1_d.base = BASE_THREE;
        s1_d.sub  = 1'b1;
        s1_d.diff = mx - pixel_i.blue;
      end
    end else begin
      if (pixel_i.green == mn) begin
        s1_d.base = BASE_FIVE;
        s1_d.sub  = 1'b0;
        s1_d.diff = mx - pixel_i.blue;
      end else begin
        s1_d.base = BASE_ONE;
        s1_d.sub  = 1'b1;
        s1_d.diff = mx - pixel_i.green;
      end
    end
  end

  // stage 2: numerator base*d +/- diff and denominator 6*d
  always_comb begin
    logic [HueW-1:0] dx, bd, df;
    dx = HueW'(s1_q.d);
    df = HueW'(s1_q.diff);
    unique case (s1_q.base)
      BASE_ONE:   bd = dx;
      BASE_THREE: bd = (dx << 1) + dx;
      BASE_FIVE:  bd = (dx << 2) + dx;
      default:    bd = dx;
    endcase
    s2_d.valid    = s1_valid_q;
    s2_d.v        = s1_q.v;
    s2_d.d        = s1_q.d;
    s2_d.n        = s1_q.sub ? (bd - df) : (bd + df);
    s2_d.den6     = (dx << 2) + (dx << 1);
    s2_d.zero     = (s1_q.d == '0);
    s2_d.sat_full = s1_q.x_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  always_comb begin
    prep_o       = s2_q;
    prep_o.valid = s2_valid_q;
  end

endmodule

`default_nettype wire

@@ rtl/rgbhsv_divider.sv @@
// pipelined restoring fraction divider: floor(num * 2^QuoW / den), num < den
// one quotient bit per register stage; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_divider #(
  parameter int unsigned DenW = 16,
  parameter int unsigned QuoW = 16
) (
  input  wire logic            clk_i,
  input  wire logic [DenW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [QuoW-1:0] quo_o
);

  logic [DenW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [DenW-1:0] rem_in, den_in, rem_d;
    logic [QuoW-1:0] quo_in, quo_d;
    logic [DenW:0]   shifted, trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign trial   = shifted - {1'b0, den_in};
    assign take    = (shifted >= {1'b0, den_in});
    assign rem_d   = take ? trial[DenW-1:0] : shifted[DenW-1:0];
    assign quo_d   = {quo_in[QuoW-2:0], take};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      quo_q[k] <= quo_d;
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// testbench for rgb_to_hsv_converter: directed corner pixels, then random pixels
// checked against a fixed-point hsv predictor kept in a small scoreboard class
// depends on rgbhsv_pkg and the converter rtl

class hsv_scoreboard;
  rgbhsv_pkg::hsv_t hsv_expected[$];
  int unsigned      mismatches = 0;
  int unsigned      results_checked = 0;

  // floor(num * 2^CompBits / den), num < den
  function logic [rgbhsv_pkg::CompBits-1:0] scaled_quotient(longint unsigned num,
                                                            longint unsigned den);
    longint unsigned q;
    q = (num << rgbhsv_pkg::CompBits) / den;
    return q[rgbhsv_pkg::CompBits-1:0];
  endfunction

  function rgbhsv_pkg::hsv_t predict_hsv(rgbhsv_pkg::rgb_t px);
    longint unsigned  r, g, b, v, x, d, n;
    rgbhsv_pkg::hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    v = r;
    if (g > v) v = g;
    if (b > v) v = b;
    x = r;
    if (g < x) x = g;
    if (b < x) x = b;
    d = v - x;
    n = 0;
    res.hue        = '0;
    res.saturation = '0;
    res.value      = px.red;
    if (g == v) res.value = px.green;
    if (b == v) res.value = px.blue;
    if (v != 0 && d != 0) begin
      if (d >= v) begin
        res.saturation = '1;
      end else begin
        res.saturation = scaled_quotient(d, v);
      end
      // later tests override earlier ones: blue beats green beats red on ties
      if (r == v) n = (g == x) ? 5 * d + (v - b) : d - (v - g);
      if (g == v) n = (b == x) ? d + (v - r) : 3 * d - (v - b);
      if (b == v) n = (r == x) ? 3 * d + (v - g) : 5 * d - (v - r);
      // a full turn wraps to zero
      if (n < 6 * d) res.hue = scaled_quotient(n, 6 * d);
    end
    return res;
  endfunction

  function void note_pixel(rgbhsv_pkg::rgb_t px);
    hsv_expected.push_back(predict_hsv(px));
  endfunction

  function void check_field(string field, logic [rgbhsv_pkg::CompBits-1:0] exp_val,
                            logic [rgbhsv_pkg::CompBits-1:0] got_val);
    if (got_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, got_val);
    end
  endfunction

  function void check_result(rgbhsv_pkg::hsv_t got);
    rgbhsv_pkg::hsv_t exp_hsv;
    if (hsv_expected.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
    end else begin
      exp_hsv = hsv_expected.pop_front();
      results_checked++;
      check_field("hue", exp_hsv.hue, got.hue);
      check_field("saturation", exp_hsv.saturation, got.saturation);
      check_field("value", exp_hsv.value, got.value);
    end
  endfunction
endclass

module tb;
  import rgbhsv_pkg::*;

  localparam int unsigned Latency = CompBits + 3;
  localparam int unsigned NumRandom = 1100;
  localparam logic [CompBits-1:0] Full = '1;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  rgb_t pixel_i;
  hsv_t result_o;

  hsv_scoreboard hsv_sb;
  int unsigned   idle_pct;
  int unsigned   pixels_sent;
  int unsigned   directed_sent;

  rgb_to_hsv_converter i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // transfers and results are both taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) hsv_sb.note_pixel(pixel_i);
    if (rst_ni && done_o) hsv_sb.check_result(result_o);
  end

  task automatic send_pixel(input rgb_t px);
    logic [63:0] junk;
    // idle cycle by cycle so about idle_pct of the cycles carry no transfer
    while ($urandom_range(99) < idle_pct) begin
      junk    = {$urandom, $urandom};
      start   <= 1'b0;
      pixel_i <= junk[$bits(rgb_t)-1:0];
      @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic send_rgb(input logic [CompBits-1:0] r, g, b);
    rgb_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    send_pixel(px);
    directed_sent++;
  endtask

  function automatic rgb_t random_pixel();
    logic [CompBits-1:0] comp[3];
    logic [CompBits-1:0] tmp;
    int unsigned         mode;
    int unsigned         j;
    rgb_t                px;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) comp[i] = CompBits'($urandom);
    case (mode)
      4: comp[1] = comp[0];
      5: begin
        comp[1] = comp[0];
        comp[2] = comp[0];
      end
      6: comp[2] = '0;
      7: for (int i = 0; i < 3; i++) comp[i] = CompBits'($urandom_range(3));
      8: for (int i = 0; i < 3; i++) comp[i] = CompBits'(Full - $urandom_range(2));
      9: comp[0] = Full;
      default: ;
    endcase
    // shuffle so every shape lands on every channel
    for (int i = 2; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = comp[i];
      comp[i] = comp[j];
      comp[j] = tmp;
    end
    px.red   = comp[0];
    px.green = comp[1];
    px.blue  = comp[2];
    return px;
  endfunction

  initial begin
    hsv_sb        = new();
    pixels_sent   = 0;
    directed_sent = 0;
    idle_pct      = 30;
    rst_ni        = 1'b0;
    start         = 1'b0;
    pixel_i       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // black, white, grey
    send_rgb('0, '0, '0);
    send_rgb(Full, Full, Full);
    send_rgb(16'h8000, 16'h8000, 16'h8000);
    // primaries and secondaries, full saturation
    send_rgb(Full, '0, '0);
    send_rgb('0, Full, '0);
    send_rgb('0, '0, Full);
    send_rgb(Full, Full, '0);
    send_rgb('0, Full, Full);
    send_rgb(Full, '0, Full);
    send_rgb(16'h0001, '0, '0);
    send_rgb('0, 16'h0001, '0);
    send_rgb('0, '0, 16'h0001);
    // hue wraps a full turn to zero
    send_rgb(Full, 16'hfffe, 16'hfffe);
    send_rgb(16'h0002, 16'h0001, 16'h0001);
    // just below and above the red boundary
    send_rgb(Full, '0, 16'h0001);
    send_rgb(Full, 16'h0001, '0);
    send_rgb(Full, 16'hfffe, '0);
    // ties on the largest and smallest component, and two pixels with no tie
    send_rgb(16'hfffe, Full, Full);
    send_rgb(Full, 16'h8000, 16'h8000);
    send_rgb(16'h1234, 16'h5678, 16'h9abc);
    send_rgb(16'h5555, 16'haaaa, Full);
    send_rgb(16'haaaa, 16'h5555, 16'haaaa);
    send_rgb(16'h0001, Full, 16'h0001);

    for (int i = 0; i < NumRandom; i++) begin
      idle_pct = (i >= 350 && i < 700) ? 0 : 30;
      send_pixel(random_pixel());
    end
    start <= 1'b0;

    while (hsv_sb.hsv_expected.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    $display("sent %0d pixels (%0d directed: greys, primaries, ties, hue wrap), %0d checked",
             pixels_sent, directed_sent, hsv_sb.results_checked);
    $display("random part mixed ties, greys, zero minimum, tiny and near-full components");
    if (hsv_sb.mismatches == 0 && hsv_sb.hsv_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_prep.sv
rtl/rgbhsv_divider.sv
rtl/rgb_to_hsv_converter.sv
verif/tb.sv
